### rtl/teq_pkg.sv
package teq_pkg;

   // Request command codes
   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_SET   = 2'd1,
      CMD_UNSET = 2'd2,
      CMD_QUERY = 2'd3
   } cmd_type;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_FIRED = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_QUERY = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   localparam logic [31:0] TIME_RESET  = 32'hFFF0_0000;
   localparam logic [26:0] CD_RESET    = 27'd1000;
   localparam logic [26:0] TICK_MAX    = 27'd99999999;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_HEAD,   // read head entry (due scan)
      ST_DUE_CHK,   // head data valid: fire or reload
      ST_EMIT,      // read next fired entry for playback
      ST_FIRE_OUT,  // fired entry data valid: load result register
      ST_RM_WALK,   // read entry p while walking for predecessor
      ST_RM_CHK,
      ST_ADD_RD,
      ST_ADD_CHK,
      ST_ADD_LINK,  // link predecessor to the inserted slot
      ST_DONE
   } state_type;

endpackage

### rtl/timed_event_queue.sv
// Timed event queue. Up to SLOTS events are kept in a linked list ordered by
// due time, held in a one-port-read synchronous slot memory (due time, client,
// id, link) with pending bits in flip-flops. A tick that does not expire the
// countdown is taken without leaving idle. When the countdown expires, the list
// head is read and checked one entry at a time; events due now are unlinked and
// then played back as results, each read and then loaded into the result
// register once it is free, so every result carries the final countdown. Set
// and unset walk the list entry by entry to unlink the slot, set walks it again
// to insert, then links the predecessor and gives the done result; a query reads
// the slot if it is pending and gives its answer. One request is worked on at a
// time; results leave through a single output register, and the next request is
// taken once the last result of the previous one is accepted.
module timed_event_queue
   import teq_pkg::*;
#(
   parameter int SLOTS       = 16,
   parameter int IDLE_RELOAD = 100000
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [3:0]  req_slot,
   input  logic [26:0] req_delay_ticks,
   input  logic [7:0]  req_client,
   input  logic [15:0] req_event_id,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [3:0]  rsp_slot_out,
   output logic [7:0]  rsp_client_out,
   output logic [15:0] rsp_id_out,
   output logic [31:0] rsp_ticks_left,
   output logic        rsp_slot_pending,
   output logic [31:0] rsp_current_time,
   output logic [26:0] rsp_next_in,
   output logic        rsp_last
);

   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int LW = AW + 1;                    // link width incl. nil
   localparam logic [LW-1:0] NIL = LW'(SLOTS);
   localparam logic [26:0] RELOAD = 27'(IDLE_RELOAD);

   // Slot memories
   logic [31:0]   due_mem  [SLOTS];
   logic [7:0]    cli_mem  [SLOTS];
   logic [15:0]   id_mem   [SLOTS];
   logic [LW-1:0] nxt_mem  [SLOTS];

   logic [SLOTS-1:0] pend_ff, pend_in;
   logic [31:0]   time_ff, time_in;
   logic [26:0]   cd_ff, cd_in;
   logic [LW-1:0] head_ff, head_in;
   state_type     st_ff, st_in;

   // Latched request
   cmd_type       cmd_ff, cmd_in;
   logic [3:0]    slot_ff, slot_in;
   logic [26:0]   tk_ff, tk_in;
   logic [7:0]    cli_ff, cli_in;
   logic [15:0]   eid_ff, eid_in;
   logic          add_ff, add_in;     // set: add after remove

   // Walk state
   logic [LW-1:0] p_ff, p_in;         // current entry
   logic [LW-1:0] prv_ff, prv_in;     // previous entry (nil = head)
   logic [26:0]   rel_ff, rel_in;

   // Fired events awaiting playback
   logic [LW-1:0] fp_ff, fp_in;       // next fired entry
   logic [LW-1:0] fc_ff, fc_in;       // fired entries left

   // Memory port
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [31:0]   rd_due;
   logic [7:0]    rd_cli;
   logic [15:0]   rd_id;
   logic [LW-1:0] rd_nxt;
   logic          wr_due;
   logic          wr_nxt;
   logic [AW-1:0] wr_addr, wn_addr;
   logic [LW-1:0] wn_data;

   // Output register
   logic          ov_ff, ov_in;
   kind_type      ok_ff, ok_in;
   logic [3:0]    os_ff, os_in;
   logic [7:0]    oc_ff, oc_in;
   logic [15:0]   oi_ff, oi_in;
   logic [31:0]   ot_ff, ot_in;
   logic          op_ff, op_in;
   logic          ol_ff, ol_in;

   logic          slot_ok;
   logic [31:0]   gap;
   logic [31:0]   due_new;

   assign slot_ok = (32'(slot_ff) < 32'(SLOTS));
   assign due_new = time_ff + 32'(tk_ff);
   assign gap     = rd_due - time_ff;
   assign wr_addr = slot_ff[AW-1:0];

   // Memory read and write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_due <= due_mem[rd_addr];
         rd_cli <= cli_mem[rd_addr];
         rd_id  <= id_mem[rd_addr];
         rd_nxt <= nxt_mem[rd_addr];
      end
      if (wr_due) begin
         due_mem[wr_addr] <= due_new;
         cli_mem[wr_addr] <= cli_ff;
         id_mem[wr_addr]  <= eid_ff;
      end
      if (wr_nxt) begin
         nxt_mem[wn_addr] <= wn_data;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_IDLE;
         pend_ff <= '0;
         time_ff <= TIME_RESET;
         cd_ff   <= CD_RESET;
         head_ff <= NIL;
         ov_ff   <= 1'b0;
      end else begin
         st_ff   <= st_in;
         pend_ff <= pend_in;
         time_ff <= time_in;
         cd_ff   <= cd_in;
         head_ff <= head_in;
         ov_ff   <= ov_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      slot_ff <= slot_in;
      tk_ff  <= tk_in;
      cli_ff <= cli_in;
      eid_ff <= eid_in;
      add_ff <= add_in;
      p_ff   <= p_in;
      prv_ff <= prv_in;
      rel_ff <= rel_in;
      fp_ff  <= fp_in;
      fc_ff  <= fc_in;
      ok_ff  <= ok_in;
      os_ff  <= os_in;
      oc_ff  <= oc_in;
      oi_ff  <= oi_in;
      ot_ff  <= ot_in;
      op_ff  <= op_in;
      ol_ff  <= ol_in;
   end

   // Sequencer
   always_comb begin
      logic [26:0] tk;
      logic        emit;
      logic        fin;
      tk = req_delay_ticks;
      st_in = st_ff; pend_in = pend_ff; time_in = time_ff; cd_in = cd_ff;
      head_in = head_ff; cmd_in = cmd_ff; slot_in = slot_ff; tk_in = tk_ff;
      cli_in = cli_ff; eid_in = eid_ff; add_in = add_ff;
      p_in = p_ff; prv_in = prv_ff; rel_in = rel_ff;
      fp_in = fp_ff; fc_in = fc_ff;
      ok_in = ok_ff; os_in = os_ff; oc_in = oc_ff; oi_in = oi_ff;
      ot_in = ot_ff; op_in = op_ff; ol_in = ol_ff;
      rd_en = 1'b0; rd_addr = '0;
      wr_due = 1'b0; wr_nxt = 1'b0; wn_addr = '0; wn_data = NIL;
      req_ready = 1'b0;
      emit = 1'b0; fin = 1'b0;

      // result register drains
      ov_in = ov_ff && !rsp_ready;

      case (st_ff)
         ST_IDLE: begin
            req_ready = !ov_ff || rsp_ready;
            if (req_valid && req_ready) begin
               if (tk == 27'd0) tk = 27'd1;
               if (tk > TICK_MAX) tk = TICK_MAX;
               cmd_in = cmd_type'(req_command);
               slot_in = req_slot; tk_in = tk;
               cli_in = req_client; eid_in = req_event_id;
               fc_in = '0;
               add_in = (cmd_type'(req_command) == CMD_SET);
               case (cmd_type'(req_command))
                  CMD_TICK: begin
                     time_in = time_ff + 32'd1;
                     cd_in = cd_ff - 27'd1;
                     if (cd_ff == 27'd1) begin
                        rel_in = RELOAD;
                        st_in = ST_RD_HEAD;
                     end
                  end
                  default: st_in = ST_RM_WALK;
               endcase
               p_in = head_ff;
               prv_in = NIL;
            end
         end

         // Due scan: read head
         ST_RD_HEAD: begin
            if (head_ff == NIL) begin
               cd_in = rel_ff;
               fin = 1'b1;
            end else begin
               rd_en = 1'b1; rd_addr = head_ff[AW-1:0];
               st_in = ST_DUE_CHK;
            end
         end

         // Unlink due head; results are played back once the countdown is final
         ST_DUE_CHK: begin
            if (gap != 32'd0) begin
               cd_in = (gap < 32'(rel_ff)) ? gap[26:0] : rel_ff;
               fin = 1'b1;
            end else begin
               if (fc_ff == '0) fp_in = head_ff;
               fc_in = fc_ff + LW'(1);
               pend_in[head_ff[AW-1:0]] = 1'b0;
               head_in = rd_nxt;
               st_in = ST_RD_HEAD;
            end
         end

         // Fired event playback, following the links of the unlinked entries
         ST_EMIT: begin
            if (fc_ff == '0) begin
               st_in = (cmd_ff == CMD_TICK) ? ST_IDLE : ST_DONE;
            end else begin
               rd_en = 1'b1; rd_addr = fp_ff[AW-1:0];
               st_in = ST_FIRE_OUT;
            end
         end

         ST_FIRE_OUT: begin
            if (!ov_ff || rsp_ready) begin
               ov_in = 1'b1; ok_in = KIND_FIRED;
               os_in = 4'(fp_ff[AW-1:0]); oc_in = rd_cli; oi_in = rd_id;
               ot_in = '0; op_in = 1'b0;
               ol_in = (cmd_ff == CMD_TICK) && (fc_ff == LW'(1));
               fp_in = rd_nxt;
               fc_in = fc_ff - LW'(1);
               st_in = ST_EMIT;
            end
         end

         // Remove walk for set/unset; query reads slot
         ST_RM_WALK: begin
            if (cmd_ff == CMD_QUERY) begin
               if (slot_ok && pend_ff[slot_ff[AW-1:0]]) begin
                  rd_en = 1'b1; rd_addr = slot_ff[AW-1:0];
                  st_in = ST_RM_CHK;
               end else begin
                  ot_in = '0; op_in = 1'b0;
                  st_in = ST_DONE;
               end
            end else if (!slot_ok || !pend_ff[slot_ff[AW-1:0]]) begin
               p_in = head_ff; prv_in = NIL;
               st_in = (slot_ok && cmd_ff == CMD_SET) ? ST_ADD_RD : ST_DONE;
            end else begin
               rd_en = 1'b1; rd_addr = p_ff[AW-1:0];
               st_in = ST_RM_CHK;
            end
         end

         ST_RM_CHK: begin
            if (cmd_ff == CMD_QUERY) begin
               ot_in = rd_due - time_ff; op_in = 1'b1;
               st_in = ST_DONE;
            end else if (p_ff == LW'(slot_ff)) begin
               // unlink found entry
               pend_in[slot_ff[AW-1:0]] = 1'b0;
               if (prv_ff == NIL) begin
                  head_in = rd_nxt;
                  if (rd_due != time_ff) begin
                     rel_in = RELOAD;
                     st_in = ST_RD_HEAD;
                  end else begin
                     st_in = add_ff ? ST_ADD_RD : ST_DONE;
                  end
               end else begin
                  wr_nxt = 1'b1; wn_addr = prv_ff[AW-1:0]; wn_data = rd_nxt;
                  st_in = add_ff ? ST_ADD_RD : ST_DONE;
               end
               p_in = (prv_ff == NIL) ? rd_nxt : head_ff;
               prv_in = NIL;
            end else begin
               prv_in = p_ff; p_in = rd_nxt;
               st_in = ST_RM_WALK;
            end
         end

         // Insertion walk
         ST_ADD_RD: begin
            if (p_ff == NIL) begin
               st_in = ST_ADD_CHK;
            end else begin
               rd_en = 1'b1; rd_addr = p_ff[AW-1:0];
               st_in = ST_ADD_CHK;
            end
         end

         ST_ADD_CHK: begin
            if (p_ff != NIL && !(32'(tk_ff) < gap)) begin
               prv_in = p_ff; p_in = rd_nxt;
               st_in = ST_ADD_RD;
            end else begin
               wr_due = 1'b1;
               wr_nxt = 1'b1; wn_addr = slot_ff[AW-1:0]; wn_data = p_ff;
               pend_in[slot_ff[AW-1:0]] = 1'b1;
               add_in = 1'b0;
               if (prv_ff == NIL) begin
                  head_in = LW'(slot_ff);
                  cd_in = tk_ff;
                  st_in = ST_EMIT;
               end else begin
                  st_in = ST_ADD_LINK;
               end
            end
         end

         // Point the predecessor at the new entry
         ST_ADD_LINK: begin
            wr_nxt = 1'b1; wn_addr = prv_ff[AW-1:0]; wn_data = LW'(slot_ff);
            st_in = ST_EMIT;
         end

         // Done or query answer
         ST_DONE: begin
            emit = 1'b1;
         end

         default: st_in = ST_IDLE;
      endcase

      // end of due scan: set continues into add, else play back fired events
      if (fin) begin
         if (add_ff) begin
            p_in = head_ff; prv_in = NIL;
            st_in = ST_ADD_RD;
         end else begin
            st_in = ST_EMIT;
         end
      end

      if (emit && (!ov_ff || rsp_ready)) begin
         ov_in = 1'b1;
         os_in = slot_ff;
         oc_in = '0; oi_in = '0;
         ol_in = 1'b1;
         if (cmd_ff == CMD_QUERY) begin
            ok_in = KIND_QUERY;
         end else begin
            ok_in = KIND_DONE;
            ot_in = '0;
            op_in = (cmd_ff == CMD_SET) && slot_ok;
         end
         st_in = ST_IDLE;
      end
   end

   // Result register outputs; time and countdown are final when results go out
   assign rsp_valid        = ov_ff;
   assign rsp_kind         = ok_ff;
   assign rsp_slot_out     = os_ff;
   assign rsp_client_out   = oc_ff;
   assign rsp_id_out       = oi_ff;
   assign rsp_ticks_left   = ot_ff;
   assign rsp_slot_pending = op_ff;
   assign rsp_current_time = time_ff;
   assign rsp_next_in      = cd_ff;
   assign rsp_last         = ol_ff;

`ifndef SYNTH
   // Nothing is accepted while the sequencer is busy
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> st_ff == ST_IDLE)
      else $error("request taken while busy");
   // Head is either empty or a pending slot
   a_head_pend: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_IDLE && head_ff != NIL) |-> pend_ff[head_ff[AW-1:0]])
      else $error("head not pending");
   // Empty list means nothing pending
   a_empty: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_IDLE && head_ff == NIL) |-> pend_ff == '0)
      else $error("pending slot off list");
`endif

endmodule
